// ===== hdl/rrle_pkg.sv =====
// ----------------------------------------------------------------------------
// rrle_pkg
// Shared types and codes of the radial run-length packet decoder.
// ----------------------------------------------------------------------------
package rrle_pkg;

    // default limits on the header counts
    localparam int unsigned RRLE_MAX_RADIALS   = 1000;
    localparam int unsigned RRLE_MAX_RUN_BYTES = 1000;

    // result kinds
    localparam logic [1:0] KIND_BIN    = 2'd0;
    localparam logic [1:0] KIND_RADIAL = 2'd1;
    localparam logic [1:0] KIND_HEADER = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_RADIALS = 2'd1;
    localparam logic [1:0] ERR_RUN     = 2'd2;
    localparam logic [1:0] ERR_OVERRUN = 2'd3;

    // highest bin position plus one
    localparam logic [14:0] BIN_CAP = 15'd16384;

    // width of the shared compare unit operands
    localparam int unsigned CMP_W = 17;

    // one result beat
    typedef struct packed {
        logic [1:0]         kind;
        logic [9:0]         radial_number;
        logic [13:0]        bin_index;
        logic [3:0]         colour_code;
        logic signed [15:0] start_angle;
        logic signed [15:0] angle_step;
        logic signed [15:0] header_word;
        logic [2:0]         header_slot;
        logic [1:0]         error_code;
        logic               last;
    } rrle_result_t;

endpackage

// ===== hdl/rrle_cmp.sv =====
// ----------------------------------------------------------------------------
// rrle_cmp
// Shared unsigned less-than unit, built on one subtractor.
// ----------------------------------------------------------------------------
module rrle_cmp (
    input  logic [rrle_pkg::CMP_W-1:0] a,
    input  logic [rrle_pkg::CMP_W-1:0] b,
    output logic                       lt
);
    import rrle_pkg::*;

    logic [CMP_W:0] diff;

    // borrow out of a - b means a < b
    assign diff = {1'b0, a} - {1'b0, b};
    assign lt   = diff[CMP_W];

endmodule

// ===== hdl/rrle_obuf.sv =====
// ----------------------------------------------------------------------------
// rrle_obuf
// Output register that holds one result beat until it is taken.
// ----------------------------------------------------------------------------
module rrle_obuf (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push_valid,
    input  rrle_pkg::rrle_result_t push_data,
    output logic                   free,
    output logic                   out_valid,
    input  logic                   out_ready,
    output rrle_pkg::rrle_result_t out_data
);
    import rrle_pkg::*;

    logic         valid_reg;
    rrle_result_t data_reg;

    // slot can take a beat when empty or emptied this cycle
    assign free      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push_valid && free)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (push_valid && free)
        begin
            data_reg <= push_data;
        end
    end

endmodule

// ===== hdl/rrle_seq.sv =====
// ----------------------------------------------------------------------------
// rrle_seq
// Parse sequencer: holds the packet state, drives the shared compare unit
// and issues result beats, at most one per cycle and only while the output register is free.
// ----------------------------------------------------------------------------
module rrle_seq #(
    parameter int unsigned MAX_RADIALS   = rrle_pkg::RRLE_MAX_RADIALS,
    parameter int unsigned MAX_RUN_BYTES = rrle_pkg::RRLE_MAX_RUN_BYTES
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [7:0]                 data_byte,
    input  logic                       packet_start,
    input  logic                       in_valid,
    output logic                       in_ready,
    output logic                       push_valid,
    output rrle_pkg::rrle_result_t     push_data,
    input  logic                       out_free,
    output logic [rrle_pkg::CMP_W-1:0] cmp_a,
    output logic [rrle_pkg::CMP_W-1:0] cmp_b,
    input  logic                       cmp_lt
);
    import rrle_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_DECODE, ST_BINS, ST_ERR} step_t;
    typedef enum logic [2:0] {PH_PKT, PH_RADHDR, PH_RUNS, PH_DONE, PH_FAIL} phase_t;

    step_t        step_reg,       step_next;
    phase_t       phase_reg,      phase_next;
    logic [7:0]   byte_reg,       byte_next;
    logic [3:0]   bwi_reg,        bwi_next;
    logic [7:0]   high_reg,       high_next;
    logic [14:0]  limit_reg,      limit_next;
    logic [9:0]   rad_left_reg,   rad_left_next;
    logic [9:0]   rad_cnt_reg,    rad_cnt_next;
    logic [10:0]  run_left_reg,   run_left_next;
    logic [14:0]  bin_pos_reg,    bin_pos_next;
    logic [15:0]  count_hold_reg, count_hold_next;
    logic [15:0]  angle_hold_reg, angle_hold_next;
    logic [3:0]   reps_reg,       reps_next;
    logic [1:0]   err_reg,        err_next;

    logic [15:0]  word;
    logic [2:0]   slot;
    logic         bad;
    logic         do_finish;
    logic         do_end_hdr;
    logic [15:0]  pos_sum;

    assign word    = {high_reg, byte_reg};
    assign slot    = bwi_reg[3:1];
    assign pos_sum = {1'b0, bin_pos_reg} + {12'd0, reps_reg};

    // operand select for the shared compare unit
    always_comb
    begin
        cmp_a = '0;
        cmp_b = '0;
        case (step_reg)
            ST_DECODE:
            begin
                if (phase_reg == PH_PKT)
                begin
                    cmp_a = CMP_W'(MAX_RADIALS);
                    cmp_b = {2'b00, word[14:0]};
                end
                else
                begin
                    cmp_a = CMP_W'(MAX_RUN_BYTES);
                    cmp_b = {1'b0, count_hold_reg[14:0], 1'b0};
                end
            end
            ST_BINS:
            begin
                cmp_a = {2'b00, bin_pos_reg};
                cmp_b = {2'b00, limit_reg};
            end
            default:
            begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
    end

    // sequencer next state
    always_comb
    begin
        step_next       = step_reg;
        phase_next      = phase_reg;
        byte_next       = byte_reg;
        bwi_next        = bwi_reg;
        high_next       = high_reg;
        limit_next      = limit_reg;
        rad_left_next   = rad_left_reg;
        rad_cnt_next    = rad_cnt_reg;
        run_left_next   = run_left_reg;
        bin_pos_next    = bin_pos_reg;
        count_hold_next = count_hold_reg;
        angle_hold_next = angle_hold_reg;
        reps_next       = reps_reg;
        err_next        = err_reg;
        in_ready        = 1'b0;
        push_valid      = 1'b0;
        push_data       = '0;
        bad             = 1'b0;
        do_finish       = 1'b0;
        do_end_hdr      = 1'b0;

        case (step_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    byte_next = data_byte;
                    step_next = ST_DECODE;
                    // new packet: clear the parse state
                    if (packet_start)
                    begin
                        phase_next      = PH_PKT;
                        bwi_next        = '0;
                        high_next       = '0;
                        limit_next      = '0;
                        rad_left_next   = '0;
                        rad_cnt_next    = '0;
                        run_left_next   = '0;
                        bin_pos_next    = '0;
                        count_hold_next = '0;
                        angle_hold_next = '0;
                    end
                end
            end

            ST_DECODE:
            begin
                case (phase_reg)
                    PH_PKT, PH_RADHDR:
                    begin
                        if (!bwi_reg[0])
                        begin
                            // high byte of a word
                            high_next = byte_reg;
                            bwi_next  = bwi_reg + 4'd1;
                            step_next = ST_IDLE;
                        end
                        else if (phase_reg == PH_PKT)
                        begin
                            // packet header word
                            bad                   = (slot == 3'd5) && (word[15] || cmp_lt);
                            push_valid            = 1'b1;
                            push_data.kind        = KIND_HEADER;
                            push_data.header_word = word;
                            push_data.header_slot = slot;
                            push_data.last        = !bad;
                            if (out_free)
                            begin
                                step_next = ST_IDLE;
                                if (slot == 3'd1)
                                begin
                                    limit_next = (word > 16'(BIN_CAP)) ? BIN_CAP : word[14:0];
                                end
                                if (slot == 3'd5)
                                begin
                                    bwi_next = '0;
                                    if (bad)
                                    begin
                                        err_next  = ERR_RADIALS;
                                        step_next = ST_ERR;
                                    end
                                    else
                                    begin
                                        rad_left_next = word[9:0];
                                        rad_cnt_next  = '0;
                                        phase_next    = (word == 16'd0) ? PH_DONE : PH_RADHDR;
                                    end
                                end
                                else
                                begin
                                    bwi_next = bwi_reg + 4'd1;
                                end
                            end
                        end
                        else if (slot == 3'd0)
                        begin
                            count_hold_next = word;
                            bwi_next        = bwi_reg + 4'd1;
                            step_next       = ST_IDLE;
                        end
                        else if (slot == 3'd1)
                        begin
                            angle_hold_next = word;
                            bwi_next        = bwi_reg + 4'd1;
                            step_next       = ST_IDLE;
                        end
                        else
                        begin
                            // radial header complete
                            bad                     = count_hold_reg[15] || cmp_lt;
                            push_valid              = 1'b1;
                            push_data.kind          = KIND_RADIAL;
                            push_data.radial_number = rad_cnt_reg;
                            push_data.start_angle   = angle_hold_reg;
                            push_data.angle_step    = word;
                            push_data.last          = !bad;
                            if (out_free)
                            begin
                                bwi_next  = '0;
                                step_next = ST_IDLE;
                                if (bad)
                                begin
                                    err_next  = ERR_RUN;
                                    step_next = ST_ERR;
                                end
                                else
                                begin
                                    run_left_next = {count_hold_reg[9:0], 1'b0};
                                    bin_pos_next  = '0;
                                    if (count_hold_reg == 16'd0)
                                    begin
                                        do_end_hdr = 1'b1;
                                    end
                                    else
                                    begin
                                        phase_next = PH_RUNS;
                                    end
                                end
                            end
                        end
                    end
                    PH_RUNS:
                    begin
                        // zero-length run gives no beat
                        if (byte_reg[7:4] == 4'd0)
                        begin
                            do_finish = 1'b1;
                            step_next = ST_IDLE;
                        end
                        else
                        begin
                            reps_next = byte_reg[7:4];
                            step_next = ST_BINS;
                        end
                    end
                    default:
                    begin
                        step_next = ST_IDLE;
                    end
                endcase
            end

            ST_BINS:
            begin
                if (cmp_lt)
                begin
                    // bin inside the radial
                    push_valid              = 1'b1;
                    push_data.kind          = KIND_BIN;
                    push_data.radial_number = rad_cnt_reg;
                    push_data.bin_index     = bin_pos_reg[13:0];
                    push_data.colour_code   = byte_reg[3:0];
                    push_data.last          = (reps_reg == 4'd1);
                    if (out_free)
                    begin
                        bin_pos_next = bin_pos_reg + 15'd1;
                        reps_next    = reps_reg - 4'd1;
                        if (reps_reg == 4'd1)
                        begin
                            do_finish = 1'b1;
                            step_next = ST_IDLE;
                        end
                    end
                end
                else
                begin
                    // rest of the run falls past the radial
                    bin_pos_next = (pos_sum > 16'(BIN_CAP)) ? BIN_CAP : pos_sum[14:0];
                    err_next     = ERR_OVERRUN;
                    step_next    = ST_ERR;
                end
            end

            ST_ERR:
            begin
                push_valid              = 1'b1;
                push_data.kind          = KIND_ERROR;
                push_data.radial_number = rad_cnt_reg;
                push_data.error_code    = err_reg;
                push_data.last          = 1'b1;
                if (out_free)
                begin
                    step_next = ST_IDLE;
                    if (err_reg == ERR_OVERRUN)
                    begin
                        do_finish = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_FAIL;
                    end
                end
            end

            default:
            begin
                step_next = ST_IDLE;
            end
        endcase

        // run byte consumed
        if (do_finish)
        begin
            run_left_next = run_left_reg - 11'd1;
        end

        // radial finished
        if (do_end_hdr || (do_finish && run_left_reg == 11'd1))
        begin
            rad_cnt_next  = rad_cnt_reg + 10'd1;
            rad_left_next = rad_left_reg - 10'd1;
            bwi_next      = '0;
            phase_next    = (rad_left_reg == 10'd1) ? PH_DONE : PH_RADHDR;
        end
    end

    // state and parse registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= ST_IDLE;
            phase_reg      <= PH_PKT;
            bwi_reg        <= '0;
            high_reg       <= '0;
            limit_reg      <= '0;
            rad_left_reg   <= '0;
            rad_cnt_reg    <= '0;
            run_left_reg   <= '0;
            bin_pos_reg    <= '0;
            count_hold_reg <= '0;
            angle_hold_reg <= '0;
            reps_reg       <= '0;
            err_reg        <= ERR_NONE;
            byte_reg       <= '0;
        end
        else
        begin
            step_reg       <= step_next;
            phase_reg      <= phase_next;
            bwi_reg        <= bwi_next;
            high_reg       <= high_next;
            limit_reg      <= limit_next;
            rad_left_reg   <= rad_left_next;
            rad_cnt_reg    <= rad_cnt_next;
            run_left_reg   <= run_left_next;
            bin_pos_reg    <= bin_pos_next;
            count_hold_reg <= count_hold_next;
            angle_hold_reg <= angle_hold_next;
            reps_reg       <= reps_next;
            err_reg        <= err_next;
            byte_reg       <= byte_next;
        end
    end

endmodule

// ===== hdl/radial_rle_packet_decoder.sv =====
// ----------------------------------------------------------------------------
// radial_rle_packet_decoder
// An accepted byte is latched and decoded; a header or radial beat goes to
// the output register once it is free. A run byte of n bins issues its bin
// beats one per cycle while the output register is free, each checked by the
// shared compare, plus an error beat on overrun. Bytes are taken only in idle.
// Reset: rst_n clears all parse state at once; no clearing pass.
// ----------------------------------------------------------------------------
module radial_rle_packet_decoder #(
    parameter int unsigned MAX_RADIALS   = rrle_pkg::RRLE_MAX_RADIALS,
    parameter int unsigned MAX_RUN_BYTES = rrle_pkg::RRLE_MAX_RUN_BYTES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         data_byte,
    input  logic               packet_start,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         kind,
    output logic [9:0]         radial_number,
    output logic [13:0]        bin_index,
    output logic [3:0]         colour_code,
    output logic signed [15:0] start_angle,
    output logic signed [15:0] angle_step,
    output logic signed [15:0] header_word,
    output logic [2:0]         header_slot,
    output logic [1:0]         error_code,
    output logic               last
);
    import rrle_pkg::*;

    logic               push_valid;
    rrle_result_t       push_data;
    logic               out_free;
    logic [CMP_W-1:0]   cmp_a;
    logic [CMP_W-1:0]   cmp_b;
    logic               cmp_lt;
    rrle_result_t       res;

    // parse sequencer
    rrle_seq #(
        .MAX_RADIALS   (MAX_RADIALS),
        .MAX_RUN_BYTES (MAX_RUN_BYTES)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_byte    (data_byte),
        .packet_start (packet_start),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .push_valid   (push_valid),
        .push_data    (push_data),
        .out_free     (out_free),
        .cmp_a        (cmp_a),
        .cmp_b        (cmp_b),
        .cmp_lt       (cmp_lt)
    );

    // shared compare unit
    rrle_cmp u_cmp (
        .a  (cmp_a),
        .b  (cmp_b),
        .lt (cmp_lt)
    );

    // output register
    rrle_obuf u_obuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .free       (out_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (res)
    );

    // result fields to ports
    assign kind          = res.kind;
    assign radial_number = res.radial_number;
    assign bin_index     = res.bin_index;
    assign colour_code   = res.colour_code;
    assign start_angle   = res.start_angle;
    assign angle_step    = res.angle_step;
    assign header_word   = res.header_word;
    assign header_slot   = res.header_slot;
    assign error_code    = res.error_code;
    assign last          = res.last;

endmodule

// ===== hdl/rrle_checker.sv =====
// ----------------------------------------------------------------------------
// rrle_checker
// Port-level checks of the radial run-length packet decoder.
// ----------------------------------------------------------------------------
module rrle_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  kind,
    input logic [2:0]  header_slot,
    input logic [1:0]  error_code,
    input logic        last
);
    import rrle_pkg::*;

    // stalled beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(last))
        else $error("output beat changed while stalled");

    // the block is not ready in the cycle after it takes a byte
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken on back-to-back cycles");

    // error code only on error beats
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_ERROR |-> error_code == ERR_NONE)
        else $error("error code on a non-error beat");

    // header slot stays in range
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_HEADER |-> header_slot <= 3'd5)
        else $error("header slot out of range");

    // error always closes the byte
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_ERROR |-> last)
        else $error("error beat not marked last");

endmodule

bind radial_rle_packet_decoder rrle_checker u_rrle_checker (.*);

// ===== tb/radial_rle_packet_decoder_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radial_rle_packet_decoder_checker
// Watches both channels of the radial packet decoder. Every accepted input
// byte runs through a local decode of the packet format, and the beats it
// should cause are queued. Every output beat is compared field by field with
// the oldest queued beat.
// ----------------------------------------------------------------------------
module radial_rle_packet_decoder_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [7:0]         data_byte,
    input  logic               packet_start,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [1:0]         kind,
    input  logic [9:0]         radial_number,
    input  logic [13:0]        bin_index,
    input  logic [3:0]         colour_code,
    input  logic signed [15:0] start_angle,
    input  logic signed [15:0] angle_step,
    input  logic signed [15:0] header_word,
    input  logic [2:0]         header_slot,
    input  logic [1:0]         error_code,
    input  logic               last,
    output int                 mismatch_count,
    output int                 results_owed
);
    import rrle_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_RADIAL = 3'd1,
        PH_RUNS   = 3'd2,
        PH_DONE   = 3'd3,
        PH_FAILED = 3'd4
    } parse_phase_t;

    localparam int BEATS_PER_BYTE = 15;

    // decode state, mirrors the block after each accepted byte
    parse_phase_t phase;
    logic [3:0]   byte_pos;
    logic [7:0]   hi_byte;
    logic [15:0]  bin_limit;
    logic [9:0]   radials_to_go;
    logic [9:0]   radial_idx;
    logic [10:0]  run_left;
    logic [14:0]  bin_pos;
    logic [15:0]  count_word;
    logic [15:0]  angle_word;

    rrle_result_t byte_beats[$];
    rrle_result_t owed_beats[$];
    int           errors;
    int           beat_no;

    task automatic clear_state();
        phase         = PH_HEADER;
        byte_pos      = 4'd0;
        hi_byte       = 8'd0;
        bin_limit     = 16'd0;
        radials_to_go = 10'd0;
        radial_idx    = 10'd0;
        run_left      = 11'd0;
        bin_pos       = 15'd0;
        count_word    = 16'd0;
        angle_word    = 16'd0;
    endtask

    task automatic report(input string what);
        errors++;
        $display("%0t ns: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [15:0] got_v,
                               input logic [15:0] want_v);
        if (got_v !== want_v)
            report($sformatf("beat %0d: %s is %h, expected %h", beat_no, name, got_v, want_v));
    endtask

    // queue one beat of the current byte, up to the cap of BEATS_PER_BYTE per byte
    task automatic emit_beat(input logic [1:0] k, input logic [9:0] rad,
                             input logic [13:0] bin, input logic [3:0] col,
                             input logic [15:0] sa, input logic [15:0] step,
                             input logic [15:0] word, input logic [2:0] slot,
                             input logic [1:0] err);
        rrle_result_t r;
        r = '{k, rad, bin, col, sa, step, word, slot, err, 1'b0};
        if (byte_beats.size() < BEATS_PER_BYTE)
            byte_beats.push_back(r);
    endtask

    task automatic finish_radial();
        radial_idx    = radial_idx + 10'd1;
        radials_to_go = radials_to_go - 10'd1;
        byte_pos      = 4'd0;
        phase         = (radials_to_go != 10'd0) ? PH_RADIAL : PH_DONE;
    endtask

    // decode one packet byte and queue the beats it causes
    task automatic decode_packet_byte(input logic [7:0] b, input logic st);
        logic [15:0] word;
        logic [2:0]  slot;
        int          count;
        int          pos;
        int          reps;
        logic        overrun;
        byte_beats.delete();
        if (st)
            clear_state();
        word = {hi_byte, b};
        slot = byte_pos[3:1];
        case (phase)
            PH_HEADER:
            begin
                if (!byte_pos[0])
                begin
                    hi_byte  = b;
                    byte_pos = byte_pos + 4'd1;
                end
                else
                begin
                    emit_beat(KIND_HEADER, 10'd0, 14'd0, 4'd0, 16'd0, 16'd0, word, slot,
                              ERR_NONE);
                    if (slot == 3'd1)
                        bin_limit = word;
                    if (slot >= 3'd5)
                    begin
                        count    = $signed(word);
                        byte_pos = 4'd0;
                        if (count < 0 || count > int'(RRLE_MAX_RADIALS))
                        begin
                            emit_beat(KIND_ERROR, 10'd0, 14'd0, 4'd0, 16'd0, 16'd0, 16'd0,
                                      3'd0, ERR_RADIALS);
                            phase = PH_FAILED;
                        end
                        else
                        begin
                            radials_to_go = count[9:0];
                            radial_idx    = 10'd0;
                            phase         = (count != 0) ? PH_RADIAL : PH_DONE;
                        end
                    end
                    else
                        byte_pos = byte_pos + 4'd1;
                end
            end
            PH_RADIAL:
            begin
                if (!byte_pos[0])
                begin
                    hi_byte  = b;
                    byte_pos = byte_pos + 4'd1;
                end
                else if (slot == 3'd0)
                begin
                    count_word = word;
                    byte_pos   = byte_pos + 4'd1;
                end
                else if (slot == 3'd1)
                begin
                    angle_word = word;
                    byte_pos   = byte_pos + 4'd1;
                end
                else
                begin
                    // halfword count doubled into run bytes, no wrap
                    count = $signed(count_word);
                    count = count * 2;
                    emit_beat(KIND_RADIAL, radial_idx, 14'd0, 4'd0, angle_word, word, 16'd0,
                              3'd0, ERR_NONE);
                    byte_pos = 4'd0;
                    if (count < 0 || count > int'(RRLE_MAX_RUN_BYTES))
                    begin
                        emit_beat(KIND_ERROR, radial_idx, 14'd0, 4'd0, 16'd0, 16'd0, 16'd0,
                                  3'd0, ERR_RUN);
                        phase = PH_FAILED;
                    end
                    else
                    begin
                        run_left = count[10:0];
                        bin_pos  = 15'd0;
                        if (count == 0)
                            finish_radial();
                        else
                            phase = PH_RUNS;
                    end
                end
            end
            PH_RUNS:
            begin
                reps    = b[7:4];
                overrun = 1'b0;
                for (int k = 0; k < reps; k++)
                begin
                    pos = int'(bin_pos) + k;
                    if (pos < int'(bin_limit) && pos < int'(BIN_CAP))
                        emit_beat(KIND_BIN, radial_idx, pos[13:0], b[3:0], 16'd0, 16'd0,
                                  16'd0, 3'd0, ERR_NONE);
                    else
                        overrun = 1'b1;
                end
                pos     = int'(bin_pos) + reps;
                bin_pos = (pos > int'(BIN_CAP)) ? BIN_CAP : pos[14:0];
                if (overrun)
                    emit_beat(KIND_ERROR, radial_idx, 14'd0, 4'd0, 16'd0, 16'd0, 16'd0, 3'd0,
                              ERR_OVERRUN);
                run_left = run_left - 11'd1;
                if (run_left == 11'd0)
                    finish_radial();
            end
            default:
            begin
                // packet over or failed, byte ignored until the next start
            end
        endcase
        if (byte_beats.size() > 0)
            byte_beats[byte_beats.size() - 1].last = 1'b1;
        foreach (byte_beats[i])
            owed_beats.push_back(byte_beats[i]);
    endtask

    // compare output beats first, then queue the beats of the accepted byte
    always @(posedge clk or negedge rst_n)
    begin
        rrle_result_t got;
        rrle_result_t want;
        if (!rst_n)
        begin
            clear_state();
            owed_beats.delete();
            errors  = 0;
            beat_no = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = '{kind, radial_number, bin_index, colour_code, start_angle,
                        angle_step, header_word, header_slot, error_code, last};
                if (owed_beats.size() == 0)
                    report($sformatf("beat %0d arrived with nothing expected", beat_no));
                else
                begin
                    want = owed_beats.pop_front();
                    check_field("kind", got.kind, want.kind);
                    check_field("radial_number", got.radial_number, want.radial_number);
                    check_field("bin_index", got.bin_index, want.bin_index);
                    check_field("colour_code", got.colour_code, want.colour_code);
                    check_field("start_angle", got.start_angle, want.start_angle);
                    check_field("angle_step", got.angle_step, want.angle_step);
                    check_field("header_word", got.header_word, want.header_word);
                    check_field("header_slot", got.header_slot, want.header_slot);
                    check_field("error_code", got.error_code, want.error_code);
                    check_field("last", got.last, want.last);
                end
                beat_no++;
            end
            if (in_valid && in_ready)
                decode_packet_byte(data_byte, packet_start);
        end
        mismatch_count <= errors;
        results_owed   <= owed_beats.size();
    end

endmodule

// ===== tb/radial_rle_packet_decoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radial_rle_packet_decoder_tb
// Feeds the radial packet decoder a few hand-built packets and then random
// packets, mostly well formed with random content, plus bad counts, cut
// packets and stray bytes. The sender idles in bursts, the receiver stalls
// on its own pattern and once holds off long enough to back up the block.
// ----------------------------------------------------------------------------
module radial_rle_packet_decoder_tb;

    import rrle_pkg::*;

    typedef enum int {
        PKT_GOOD        = 0,
        PKT_NO_RADIALS  = 1,
        PKT_BAD_RADIALS = 2,
        PKT_BAD_RUN     = 3,
        PKT_CUT         = 4,
        PKT_NOISE       = 5
    } pkt_flavor_t;

    typedef struct packed {
        logic       start;
        logic [7:0] value;
    } stim_byte_t;

    localparam int RANDOM_ITEMS = 200;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 50;
    localparam int HOLD_START   = 150;
    localparam int HOLD_CYCLES  = 400;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               in_valid     = 1'b0;
    logic               in_ready;
    logic [7:0]         data_byte    = 8'd0;
    logic               packet_start = 1'b0;
    logic               out_valid;
    logic               out_ready    = 1'b0;
    logic [1:0]         kind;
    logic [9:0]         radial_number;
    logic [13:0]        bin_index;
    logic [3:0]         colour_code;
    logic signed [15:0] start_angle;
    logic signed [15:0] angle_step;
    logic signed [15:0] header_word;
    logic [2:0]         header_slot;
    logic [1:0]         error_code;
    logic               last;
    int                 mismatch_count;
    int                 results_owed;
    int                 cycle_count  = 0;

    stim_byte_t packet_bytes[$];

    radial_rle_packet_decoder dut (.*);

    radial_rle_packet_decoder_checker checker_i (.*);

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic put_byte(input logic st, input logic [7:0] b);
        packet_bytes.push_back('{st, b});
    endtask

    task automatic put_word(input logic st, input logic [15:0] w);
        put_byte(st, w[15:8]);
        put_byte(1'b0, w[7:0]);
    endtask

    // radial header and its run bytes
    task automatic put_radial(input logic [15:0] halfwords);
        int n;
        put_word(1'b0, halfwords);
        put_word(1'b0, 16'($urandom));
        put_word(1'b0, 16'($urandom));
        n = $signed(halfwords);
        if (n > 0 && n <= 500)
            for (int i = 0; i < 2 * n; i++)
                put_byte(1'b0, ($urandom_range(0, 3) == 0) ? 8'hF0 | 8'($urandom)
                                                           : 8'($urandom));
    endtask

    function automatic logic [15:0] bad_count(input int lowest);
        if ($urandom_range(0, 1) == 1)
            return 16'($urandom_range(lowest, 32767));
        return 16'h8000 | 16'($urandom_range(0, 32767));
    endfunction

    // one packet of the given flavor, random content
    task automatic add_packet(input pkt_flavor_t flavor);
        logic [15:0] radials;
        int          mark;
        int          keep;
        mark = packet_bytes.size();
        if (flavor == PKT_NOISE)
        begin
            repeat ($urandom_range(1, 4))
                put_byte(1'b0, 8'($urandom));
            return;
        end
        case (flavor)
            PKT_GOOD:        radials = 16'($urandom_range(1, 3));
            PKT_NO_RADIALS:  radials = 16'd0;
            PKT_BAD_RADIALS: radials = bad_count(1001);
            PKT_BAD_RUN:     radials = 16'($urandom_range(1, 1000));
            default:         radials = ($urandom_range(0, 1) == 1) ? 16'd1000
                                                                   : 16'($urandom_range(4, 999));
        endcase
        put_word(1'b1, 16'($urandom));
        put_word(1'b0, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, 48)));
        put_word(1'b0, 16'($urandom));
        put_word(1'b0, 16'($urandom));
        put_word(1'b0, 16'($urandom));
        put_word(1'b0, radials);
        case (flavor)
            PKT_GOOD:
                for (int r = 0; r < radials; r++)
                    put_radial(16'($urandom_range(0, 3)));
            PKT_BAD_RUN:
                put_radial(bad_count(501));
            PKT_CUT:
            begin
                put_radial(16'($urandom_range(1, 3)));
                put_radial(16'($urandom_range(0, 3)));
                // stop somewhere inside, the next packet restarts the parse
                keep = $urandom_range(1, packet_bytes.size() - mark - 1);
                while (packet_bytes.size() > mark + keep)
                    void'(packet_bytes.pop_back());
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic build_stimulus();
        int          counted;
        int          mark;
        int          pick;
        pkt_flavor_t flavor;
        // extreme header words, one radial of a zero-length run and an overrun
        put_word(1'b1, 16'h0000);
        put_word(1'b0, 16'h0003);
        put_word(1'b0, 16'hFFFF);
        put_word(1'b0, 16'h8000);
        put_word(1'b0, 16'h7FFF);
        put_word(1'b0, 16'h0001);
        put_word(1'b0, 16'h0001);
        put_word(1'b0, 16'h8000);
        put_word(1'b0, 16'h7FFF);
        put_byte(1'b0, 8'h0F);
        put_byte(1'b0, 8'hFF);
        // packet over, this one is ignored
        put_byte(1'b0, 8'h5A);
        // restart cut short inside the header
        put_byte(1'b1, 8'h12);
        put_byte(1'b0, 8'h34);
        put_byte(1'b0, 8'h00);

        // random packets, each flavor once up front
        counted = 0;
        for (int p = 0; counted < RANDOM_ITEMS; p++)
        begin
            if (p <= int'(PKT_NOISE))
                flavor = pkt_flavor_t'(p);
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    flavor = PKT_GOOD;
                else if (pick < 68)
                    flavor = PKT_NO_RADIALS;
                else if (pick < 76)
                    flavor = PKT_BAD_RADIALS;
                else if (pick < 84)
                    flavor = PKT_BAD_RUN;
                else if (pick < 92)
                    flavor = PKT_CUT;
                else
                    flavor = PKT_NOISE;
            end
            mark = packet_bytes.size();
            add_packet(flavor);
            if (flavor != PKT_NOISE)
                counted += packet_bytes.size() - mark;
        end
    endtask

    // receiver: stall pattern of its own, one long hold-off early on
    initial
    begin : receiver
        int  elapsed;
        int  mode;
        bit  held;
        elapsed = 0;
        held    = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!held && elapsed >= HOLD_START)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(1, 40))
            begin
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 1) == 1);
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge clk);
                elapsed++;
            end
        end
    end

    // reset, sender and verdict
    initial
    begin : stimulus
        int idx;
        int burst;
        int gap;
        build_stimulus();
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;

        // sender bursts with random gaps, some stretches without gaps
        idx = 0;
        while (idx < packet_bytes.size())
        begin
            burst = $urandom_range(1, 12);
            gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            while (burst > 0 && idx < packet_bytes.size())
            begin
                in_valid     <= 1'b1;
                packet_start <= packet_bytes[idx].start;
                data_byte    <= packet_bytes[idx].value;
                @(posedge clk);
                while (!in_ready)
                    @(posedge clk);
                idx++;
                burst--;
            end
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap)
                    @(posedge clk);
            end
        end
        in_valid <= 1'b0;

        // let the checker take in the last beat, then drain
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (results_owed != 0)
            $display("%0d expected beats never arrived", results_owed);
        if (mismatch_count == 0 && results_owed == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
